### rtl/adam_upd_pkg.sv
// adam_upd_pkg: shared types and constants of the adam optimizer update block
// no dependencies; imported by adam_optimizer_update

package adam_upd_pkg;

    localparam int ACC_W  = 67;
    localparam int MA_W   = 33;
    localparam int DX_W   = 80;
    localparam int DD_W   = 49;
    localparam int DQ_W   = 56;
    localparam int SX_W   = 56;
    localparam int ROOT_W = 48;
    localparam int SREM_W = 50;
    localparam int MEM_W  = 72;

    localparam logic [6:0] DIV_STEPS  = 7'd80;
    localparam logic [5:0] SQRT_STEPS = 6'd48;
    localparam logic [3:0] MOD_STEPS  = 4'd12;

    typedef enum logic [1:0] {
        REG_LR    = 2'd0,
        REG_BETA1 = 2'd1,
        REG_BETA2 = 2'd2,
        REG_EPS   = 2'd3
    } reg_idx_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD,
        ST_LOAD,
        ST_M1B,
        ST_G2,
        ST_V1A,
        ST_V1B,
        ST_V1,
        ST_PW_INIT,
        ST_PW_STEP,
        ST_PW_RES,
        ST_PW_NEXT,
        ST_PW_SQ,
        ST_DIV1,
        ST_DIV2,
        ST_SQRT,
        ST_DEN,
        ST_DIV3,
        ST_DIV3W,
        ST_SCALE,
        ST_FINAL
    } state_t;

endpackage

### rtl/adam_optimizer_update.sv
// adam_optimizer_update: fixed-point adam update of one weight per input transaction
// depends on adam_upd_pkg
//
// usage: an input transaction on s_axis carries the entry index, gradient, weight and
// step count, plus the clear_moments flag in tuser. one output transaction on m_axis
// returns the index, the updated weight and the saturated flag in tuser. the apb port
// sets learning rate, both betas and epsilon; write it only while the block is idle.
// multiplies, divides and the square root are bit serial: one shift-add multiplier (one
// multiplier bit per cycle), one restoring divider (one quotient bit per cycle) and one
// square root (one root bit per cycle) are shared by the steps of the update that need them.
// the two beta powers dominate the processing time, each costing up to 16 squarings and
// 16 multiplies in the multiplier, so the time grows with the number of bits in step+1
// and with the size of the operands.
// one transaction is processed at a time; s_axis_tready is high in the idle state.
// a finished result waits in the output register while the next transaction is taken;
// if m_axis_tready stays low, the block stalls only when the next result is ready.
// after reset the moment memory is cleared one entry per cycle through all NUM_WEIGHTS entries,
// and no transaction is taken until then; apb writes are taken at any time.

module adam_optimizer_update #(
    parameter int NUM_WEIGHTS = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,  // element_index, gradient, weight_in, step, pad
    input  logic [0:0]  s_axis_tuser,  // clear_moments
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,  // index_out, weight_out, pad
    output logic [0:0]  m_axis_tuser   // saturated
);
    import adam_upd_pkg::*;

    localparam int AW = (NUM_WEIGHTS > 1) ? $clog2(NUM_WEIGHTS) : 1;
    localparam int RW = AW + 1;
    localparam logic [RW-1:0] NW_C      = RW'(NUM_WEIGHTS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_WEIGHTS - 1);

    state_t state_reg, state_next;

    logic [23:0] lr_reg;
    logic [15:0] beta1_reg;
    logic [15:0] beta2_reg;
    logic [31:0] eps_reg;

    logic [11:0] idx_in_reg, idx_in_next;
    logic [31:0] g_reg, g_next;
    logic [31:0] w_reg, w_next;
    logic [15:0] step_reg, step_next;
    logic        clr_reg, clr_next;
    logic        sat_reg, sat_next;
    logic [11:0] mod_sh_reg, mod_sh_next;
    logic [RW-1:0] mr_reg, mr_next;
    logic [3:0]  mcnt_reg, mcnt_next;
    logic [39:0] v0_reg, v0_next;
    logic [31:0] m1_reg, m1_next;
    logic [38:0] g2_reg, g2_next;
    logic [39:0] v1_reg, v1_next;
    logic [32:0] pres_reg, pres_next;
    logic [31:0] pbase_reg, pbase_next;
    logic [16:0] pexp_reg, pexp_next;
    logic        psel_reg, psel_next;
    logic [32:0] c1_reg, c1_next;
    logic [32:0] c2_reg, c2_next;
    logic [47:0] mhat_reg, mhat_next;
    logic [DD_W-1:0] den_reg, den_next;
    logic [39:0] qv_reg, qv_next;
    logic [MA_W-1:0]  ma_reg, ma_next;
    logic [ACC_W-1:0] mb_reg, mb_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [DX_W-1:0]  dx_reg, dx_next;
    logic [DD_W-1:0]  dd_reg, dd_next;
    logic [DD_W-1:0]  drem_reg, drem_next;
    logic [DQ_W-1:0]  dq_reg, dq_next;
    logic        dovf_reg, dovf_next;
    logic [6:0]  dcnt_reg, dcnt_next;
    logic [SX_W-1:0]   sx_reg, sx_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [SREM_W-1:0] srem_reg, srem_next;
    logic [5:0]  scnt_reg, scnt_next;
    logic [AW-1:0] clr_addr_reg, clr_addr_next;
    logic        out_valid_reg, out_valid_next;
    logic [11:0] out_idx_reg, out_idx_next;
    logic [31:0] out_w_reg, out_w_next;
    logic        out_sat_reg, out_sat_next;

    logic [MEM_W-1:0] mem [NUM_WEIGHTS];
    logic [MEM_W-1:0] rd_data_reg;
    logic             mem_we;
    logic             mem_re;
    logic [AW-1:0]    mem_waddr;
    logic [MEM_W-1:0] mem_wdata;

    logic            mul_idle;
    logic            div_idle;
    logic [DD_W:0]   div_rs;
    logic [DD_W:0]   div_sub;
    logic            div_ge;
    logic [SREM_W+1:0] sq_rs;
    logic [SREM_W+1:0] sq_trial;
    logic [SREM_W+1:0] sq_sub;
    logic            sq_ge;
    logic [RW-1:0]   mod_rs;
    logic            mod_ge;
    logic [31:0]     m0_mem;
    logic [39:0]     v0_mem;
    logic [31:0]     gabs;
    logic            m1_ok;
    logic [31:0]     m1_val;
    logic            v1_ok;
    logic [39:0]     v1_val;
    logic [32:0]     pw_c;
    logic [32:0]     c_val;
    logic [31:0]     mabs;
    logic [DD_W-1:0] den_sum;
    logic            q_over;
    logic [39:0]     q_val;
    logic [39:0]     u_val;
    logic [41:0]     res_sum;
    logic            res_ok;
    logic [31:0]     res_val;
    logic [15:0]     beta_sel;
    logic            cfg_wr;

    assign pready        = 1'b1;
    assign cfg_wr        = psel && penable && pwrite;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'd0, out_w_reg, out_idx_reg};
    assign m_axis_tuser  = out_sat_reg;

    always_comb
    begin
        unique case (reg_idx_t'(paddr[3:2]))
            REG_LR:    prdata = {8'd0, lr_reg};
            REG_BETA1: prdata = {16'd0, beta1_reg};
            REG_BETA2: prdata = {16'd0, beta2_reg};
            REG_EPS:   prdata = eps_reg;
            default:   prdata = 32'd0;
        endcase
    end

    assign mul_idle = (ma_reg == '0);
    assign div_idle = (dcnt_reg == '0);

    // one quotient bit per cycle
    assign div_rs  = {drem_reg, dx_reg[DX_W-1]};
    assign div_ge  = (div_rs >= {1'b0, dd_reg});
    assign div_sub = div_rs - {1'b0, dd_reg};

    // one root bit per cycle
    assign sq_rs    = {srem_reg, sx_reg[SX_W-1:SX_W-2]};
    assign sq_trial = {2'b00, root_reg, 2'b01};
    assign sq_ge    = (sq_rs >= sq_trial);
    assign sq_sub   = sq_rs - sq_trial;

    // index reduction, one index bit per cycle
    assign mod_rs = {mr_reg[AW-1:0], mod_sh_reg[11]};
    assign mod_ge = (mod_rs >= NW_C);

    assign m0_mem = clr_reg ? 32'd0 : rd_data_reg[31:0];
    assign v0_mem = clr_reg ? 40'd0 : rd_data_reg[71:32];
    assign gabs   = g_reg[31] ? (~g_reg + 32'd1) : g_reg;

    assign m1_ok  = (acc_reg[ACC_W-1:47] == {(ACC_W-47){acc_reg[47]}});
    assign m1_val = m1_ok ? acc_reg[47:16]
                          : (acc_reg[ACC_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF);
    assign v1_ok  = (acc_reg[ACC_W-1:56] == '0);
    assign v1_val = v1_ok ? acc_reg[55:16] : 40'hFF_FFFF_FFFF;

    assign pw_c  = 33'h1_0000_0000 - pres_reg;
    assign c_val = (pw_c == '0) ? 33'd1 : pw_c;
    assign mabs  = m1_reg[31] ? (~m1_reg + 32'd1) : m1_reg;

    assign den_sum = {1'b0, root_reg} + {17'd0, eps_reg};
    assign q_over  = dovf_reg || (dq_reg[DQ_W-1:40] != '0);
    assign q_val   = q_over ? 40'hFF_FFFF_FFFF : dq_reg[39:0];

    assign u_val   = acc_reg[63:24];
    assign res_sum = m1_reg[31] ? ({{10{w_reg[31]}}, w_reg} + {2'b00, u_val})
                                : ({{10{w_reg[31]}}, w_reg} - {2'b00, u_val});
    assign res_ok  = (res_sum[41:31] == {11{res_sum[31]}});
    assign res_val = res_ok ? res_sum[31:0]
                            : (res_sum[41] ? 32'h8000_0000 : 32'h7FFF_FFFF);

    assign beta_sel = psel_reg ? beta2_reg : beta1_reg;

    always_comb
    begin
        state_next     = state_reg;
        idx_in_next    = idx_in_reg;
        g_next         = g_reg;
        w_next         = w_reg;
        step_next      = step_reg;
        clr_next       = clr_reg;
        sat_next       = sat_reg;
        mod_sh_next    = mod_sh_reg;
        mr_next        = mr_reg;
        mcnt_next      = mcnt_reg;
        v0_next        = v0_reg;
        m1_next        = m1_reg;
        g2_next        = g2_reg;
        v1_next        = v1_reg;
        pres_next      = pres_reg;
        pbase_next     = pbase_reg;
        pexp_next      = pexp_reg;
        psel_next      = psel_reg;
        c1_next        = c1_reg;
        c2_next        = c2_reg;
        mhat_next      = mhat_reg;
        den_next       = den_reg;
        qv_next        = qv_reg;
        dx_next        = dx_reg;
        dd_next        = dd_reg;
        drem_next      = drem_reg;
        dq_next        = dq_reg;
        dovf_next      = dovf_reg;
        dcnt_next      = dcnt_reg;
        sx_next        = sx_reg;
        root_next      = root_reg;
        srem_next      = srem_reg;
        scnt_next      = scnt_reg;
        clr_addr_next  = clr_addr_reg;
        out_valid_next = out_valid_reg;
        out_idx_next   = out_idx_reg;
        out_w_next     = out_w_reg;
        out_sat_next   = out_sat_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_waddr      = mr_reg[AW-1:0];
        mem_wdata      = {v1_reg, m1_reg};

        // shift-add multiplier step
        ma_next  = ma_reg >> 1;
        mb_next  = mb_reg << 1;
        acc_next = ma_reg[0] ? (acc_reg + mb_reg) : acc_reg;

        if (dcnt_reg != '0)
        begin
            drem_next = div_ge ? div_sub[DD_W-1:0] : div_rs[DD_W-1:0];
            dq_next   = {dq_reg[DQ_W-2:0], div_ge};
            dovf_next = dovf_reg | dq_reg[DQ_W-1];
            dx_next   = dx_reg << 1;
            dcnt_next = dcnt_reg - 7'd1;
        end

        if (scnt_reg != '0)
        begin
            srem_next = sq_ge ? sq_sub[SREM_W-1:0] : sq_rs[SREM_W-1:0];
            root_next = {root_reg[ROOT_W-2:0], sq_ge};
            sx_next   = sx_reg << 2;
            scnt_next = scnt_reg - 6'd1;
        end

        if (mcnt_reg != '0)
        begin
            mr_next     = mod_ge ? (mod_rs - NW_C) : mod_rs;
            mod_sh_next = mod_sh_reg << 1;
            mcnt_next   = mcnt_reg - 4'd1;
        end

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_addr_reg;
                mem_wdata = '0;
                if (clr_addr_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + AW'(1);
                end
            end
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    idx_in_next = s_axis_tdata[11:0];
                    g_next      = s_axis_tdata[43:12];
                    w_next      = s_axis_tdata[75:44];
                    step_next   = s_axis_tdata[91:76];
                    clr_next    = s_axis_tuser[0];
                    sat_next    = 1'b0;
                    mod_sh_next = s_axis_tdata[11:0];
                    mr_next     = '0;
                    mcnt_next   = MOD_STEPS;
                    state_next  = ST_MOD;
                end
            end
            ST_MOD:
            begin
                if (mcnt_reg == '0)
                begin
                    mem_re     = 1'b1;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                v0_next    = v0_mem;
                acc_next   = ACC_W'(32768);
                ma_next    = {17'd0, beta1_reg};
                mb_next    = {{(ACC_W-32){m0_mem[31]}}, m0_mem};
                state_next = ST_M1B;
            end
            ST_M1B:
            begin
                if (mul_idle)
                begin
                    ma_next    = {16'd0, 17'h1_0000 - {1'b0, beta1_reg}};
                    mb_next    = {{(ACC_W-32){g_reg[31]}}, g_reg};
                    state_next = ST_G2;
                end
            end
            ST_G2:
            begin
                if (mul_idle)
                begin
                    m1_next    = m1_val;
                    sat_next   = sat_reg | ~m1_ok;
                    acc_next   = ACC_W'(8388608);
                    ma_next    = {1'b0, gabs};
                    mb_next    = {{(ACC_W-32){1'b0}}, gabs};
                    state_next = ST_V1A;
                end
            end
            ST_V1A:
            begin
                if (mul_idle)
                begin
                    g2_next    = acc_reg[62:24];
                    acc_next   = ACC_W'(32768);
                    ma_next    = {17'd0, beta2_reg};
                    mb_next    = {{(ACC_W-40){1'b0}}, v0_reg};
                    state_next = ST_V1B;
                end
            end
            ST_V1B:
            begin
                if (mul_idle)
                begin
                    ma_next    = {16'd0, 17'h1_0000 - {1'b0, beta2_reg}};
                    mb_next    = {{(ACC_W-39){1'b0}}, g2_reg};
                    state_next = ST_V1;
                end
            end
            ST_V1:
            begin
                if (mul_idle)
                begin
                    v1_next    = v1_val;
                    sat_next   = sat_reg | ~v1_ok;
                    psel_next  = 1'b0;
                    state_next = ST_PW_INIT;
                end
            end
            ST_PW_INIT:
            begin
                pres_next  = 33'h1_0000_0000;
                pbase_next = {beta_sel, 16'd0};
                pexp_next  = {1'b0, step_reg} + 17'd1;
                state_next = ST_PW_STEP;
            end
            ST_PW_STEP:
            begin
                if (pexp_reg[0])
                begin
                    acc_next   = {{(ACC_W-32){1'b0}}, 32'h8000_0000};
                    ma_next    = pres_reg;
                    mb_next    = {{(ACC_W-32){1'b0}}, pbase_reg};
                    state_next = ST_PW_RES;
                end
                else
                begin
                    state_next = ST_PW_NEXT;
                end
            end
            ST_PW_RES:
            begin
                if (mul_idle)
                begin
                    pres_next  = acc_reg[64:32];
                    state_next = ST_PW_NEXT;
                end
            end
            ST_PW_NEXT:
            begin
                if (pexp_reg[16:1] == '0)
                begin
                    if (psel_reg)
                    begin
                        c2_next    = c_val;
                        state_next = ST_DIV1;
                    end
                    else
                    begin
                        c1_next    = c_val;
                        psel_next  = 1'b1;
                        state_next = ST_PW_INIT;
                    end
                end
                else
                begin
                    pexp_next  = pexp_reg >> 1;
                    acc_next   = {{(ACC_W-32){1'b0}}, 32'h8000_0000};
                    ma_next    = {1'b0, pbase_reg};
                    mb_next    = {{(ACC_W-32){1'b0}}, pbase_reg};
                    state_next = ST_PW_SQ;
                end
            end
            ST_PW_SQ:
            begin
                if (mul_idle)
                begin
                    pbase_next = acc_reg[63:32];
                    state_next = ST_PW_STEP;
                end
            end
            ST_DIV1:
            begin
                dx_next    = {16'd0, mabs, 32'd0};
                dd_next    = {16'd0, c1_reg};
                drem_next  = '0;
                dq_next    = '0;
                dovf_next  = 1'b0;
                dcnt_next  = DIV_STEPS;
                state_next = ST_DIV2;
            end
            ST_DIV2:
            begin
                if (div_idle)
                begin
                    mhat_next  = dq_reg[47:0];
                    dx_next    = {8'd0, v1_reg, 32'd0};
                    dd_next    = {16'd0, c2_reg};
                    drem_next  = '0;
                    dq_next    = '0;
                    dovf_next  = 1'b0;
                    dcnt_next  = DIV_STEPS;
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                if (div_idle)
                begin
                    sx_next    = dq_reg;
                    root_next  = '0;
                    srem_next  = '0;
                    scnt_next  = SQRT_STEPS;
                    state_next = ST_DEN;
                end
            end
            ST_DEN:
            begin
                if (scnt_reg == '0)
                begin
                    den_next   = den_sum;
                    state_next = ST_DIV3;
                end
            end
            ST_DIV3:
            begin
                if (mhat_reg == '0)
                begin
                    qv_next    = '0;
                    state_next = ST_SCALE;
                end
                else if (den_reg == '0)
                begin
                    qv_next    = 40'hFF_FFFF_FFFF;
                    sat_next   = 1'b1;
                    state_next = ST_SCALE;
                end
                else
                begin
                    dx_next    = {mhat_reg, 32'd0};
                    dd_next    = den_reg;
                    drem_next  = '0;
                    dq_next    = '0;
                    dovf_next  = 1'b0;
                    dcnt_next  = DIV_STEPS;
                    state_next = ST_DIV3W;
                end
            end
            ST_DIV3W:
            begin
                if (div_idle)
                begin
                    qv_next    = q_val;
                    sat_next   = sat_reg | q_over;
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                acc_next   = '0;
                ma_next    = {9'd0, lr_reg};
                mb_next    = {{(ACC_W-40){1'b0}}, qv_reg};
                state_next = ST_FINAL;
            end
            ST_FINAL:
            begin
                if (mul_idle && (!out_valid_reg || m_axis_tready))
                begin
                    out_valid_next = 1'b1;
                    out_idx_next   = idx_in_reg;
                    out_w_next     = res_val;
                    out_sat_next   = sat_reg | ~res_ok;
                    mem_we         = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
            ma_reg        <= '0;
            dcnt_reg      <= '0;
            scnt_reg      <= '0;
            mcnt_reg      <= '0;
            psel_reg      <= 1'b0;
            lr_reg        <= 24'd16777;
            beta1_reg     <= 16'd58982;
            beta2_reg     <= 16'd65470;
            eps_reg       <= 32'd43;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= out_valid_next;
            ma_reg        <= ma_next;
            dcnt_reg      <= dcnt_next;
            scnt_reg      <= scnt_next;
            mcnt_reg      <= mcnt_next;
            psel_reg      <= psel_next;
            if (cfg_wr)
            begin
                unique case (reg_idx_t'(paddr[3:2]))
                    REG_LR:    lr_reg    <= pwdata[23:0];
                    REG_BETA1: beta1_reg <= pwdata[15:0];
                    REG_BETA2: beta2_reg <= pwdata[15:0];
                    REG_EPS:   eps_reg   <= pwdata;
                    default:   lr_reg    <= lr_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_in_reg  <= idx_in_next;
        g_reg       <= g_next;
        w_reg       <= w_next;
        step_reg    <= step_next;
        clr_reg     <= clr_next;
        sat_reg     <= sat_next;
        mod_sh_reg  <= mod_sh_next;
        mr_reg      <= mr_next;
        v0_reg      <= v0_next;
        m1_reg      <= m1_next;
        g2_reg      <= g2_next;
        v1_reg      <= v1_next;
        pres_reg    <= pres_next;
        pbase_reg   <= pbase_next;
        pexp_reg    <= pexp_next;
        c1_reg      <= c1_next;
        c2_reg      <= c2_next;
        mhat_reg    <= mhat_next;
        den_reg     <= den_next;
        qv_reg      <= qv_next;
        mb_reg      <= mb_next;
        acc_reg     <= acc_next;
        dx_reg      <= dx_next;
        dd_reg      <= dd_next;
        drem_reg    <= drem_next;
        dq_reg      <= dq_next;
        dovf_reg    <= dovf_next;
        sx_reg      <= sx_next;
        root_reg    <= root_next;
        srem_reg    <= srem_next;
        out_idx_reg <= out_idx_next;
        out_w_reg   <= out_w_next;
        out_sat_reg <= out_sat_next;
    end

    // moment memory: {second moment, first moment}
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mr_reg[AW-1:0]];
        end
    end

endmodule
